// File: design/cls_pkg.sv
package cls_pkg;

  localparam int COORD_WIDTH = 16;

  localparam logic [3:0] ACT_HEAD   = 4'd0;
  localparam logic [3:0] ACT_TAIL   = 4'd1;
  localparam logic [3:0] ACT_PREV   = 4'd2;
  localparam logic [3:0] ACT_NEXT   = 4'd3;
  localparam logic [3:0] ACT_READ   = 4'd4;
  localparam logic [3:0] ACT_REMOVE = 4'd5;
  localparam logic [3:0] ACT_INSERT = 4'd6;
  localparam logic [3:0] ACT_SEARCH = 4'd7;
  localparam logic [3:0] ACT_CLEAR  = 4'd8;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_REFUSED = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  // Datapath commands issued by the controller.
  localparam logic [3:0] CMD_NONE      = 4'd0;
  localparam logic [3:0] CMD_LATCH     = 4'd1;  // capture item, read links of cursor/sentinel
  localparam logic [3:0] CMD_MOVE_HEAD = 4'd2;
  localparam logic [3:0] CMD_MOVE_TAIL = 4'd3;
  localparam logic [3:0] CMD_MOVE_PREV = 4'd4;
  localparam logic [3:0] CMD_MOVE_NEXT = 4'd5;
  localparam logic [3:0] CMD_REMOVE    = 4'd6;
  localparam logic [3:0] CMD_INSERT    = 4'd7;
  localparam logic [3:0] CMD_SRCH_INIT = 4'd8;
  localparam logic [3:0] CMD_SRCH_STEP = 4'd9;
  localparam logic [3:0] CMD_CLEAR     = 4'd10;
  localparam logic [3:0] CMD_FETCH     = 4'd11; // read entry under cursor
  localparam logic [3:0] CMD_CLR_STEP  = 4'd12;
  localparam logic [3:0] CMD_SRCH_LOAD = 4'd13; // read coordinates of the walk node

  typedef struct packed {
    logic [3:0] op;
  } cls_cmd_t;

  typedef struct packed {
    logic list_empty;
    logic off;
    logic full;
    logic walk_end;
    logic walk_hit;
    logic clr_done;
  } cls_stat_t;

endpackage

// File: design/cls_datapath.sv
module cls_datapath #(
  parameter int CAPACITY    = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  cls_pkg::cls_cmd_t            cmd,
  output cls_pkg::cls_stat_t           stat,
  input  logic signed [15:0]           coord_x,
  input  logic signed [15:0]           coord_y,
  output logic signed [15:0]           out_x,
  output logic signed [15:0]           out_y,
  output logic                         on_entry
);
  import cls_pkg::*;

  localparam int NW = $clog2(CAPACITY + 1);
  localparam int FW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);

  logic [NW-1:0]          next_mem [CAPACITY+1];
  logic [NW-1:0]          prev_mem [CAPACITY+1];
  logic [COORD_WIDTH-1:0] xm [CAPACITY];
  logic [COORD_WIDTH-1:0] ym [CAPACITY];
  logic [NW-1:0]          free_mem [CAPACITY];

  logic [NW-1:0] cursor, walk;
  logic [FW-1:0] free_count;
  logic [NW-1:0] cur_next, cur_prev, head, tail, free_top;
  logic [COORD_WIDTH-1:0] kx, ky, wx, wy, rx, ry;
  logic [FW-1:0] steps;
  logic [AW-1:0] clr_idx;
  logic          clr_run;

  // Sentinel links are kept in registers so reset sets them at once.
  // Link store: entries link to 0 only via the sentinel; sentinel reads come from head/tail.
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor     <= '0;
      head       <= '0;
      tail       <= '0;
      free_count <= FW'(CAPACITY);
      clr_run    <= 1'b1;
      clr_idx    <= '0;
      walk       <= '0;
      steps      <= '0;
    end else begin
      case (cmd.op)
        CMD_LATCH: begin
          kx       <= coord_x[COORD_WIDTH-1:0];
          ky       <= coord_y[COORD_WIDTH-1:0];
          cur_next <= (cursor == '0) ? head : next_mem[cursor];
          cur_prev <= (cursor == '0) ? tail : prev_mem[cursor];
          if (free_count != '0) free_top <= free_mem[AW'(free_count - 1'b1)];
        end
        CMD_MOVE_HEAD: cursor <= head;
        CMD_MOVE_TAIL: cursor <= tail;
        CMD_MOVE_PREV: cursor <= cur_prev;
        CMD_MOVE_NEXT: cursor <= cur_next;
        CMD_REMOVE: begin
          if (cur_prev == '0) head <= cur_next; else next_mem[cur_prev] <= cur_next;
          if (cur_next == '0) tail <= cur_prev; else prev_mem[cur_next] <= cur_prev;
          if (free_count < FW'(CAPACITY)) begin
            free_mem[AW'(free_count)] <= cursor;
            free_count <= free_count + 1'b1;
          end
          cursor <= cur_prev;
        end
        CMD_INSERT: begin
          xm[AW'(free_top - 1'b1)] <= kx;
          ym[AW'(free_top - 1'b1)] <= ky;
          prev_mem[free_top]  <= cursor;
          next_mem[free_top]  <= cur_next;
          if (cur_next == '0) tail <= free_top; else prev_mem[cur_next] <= free_top;
          if (cursor == '0) head <= free_top; else next_mem[cursor] <= free_top;
          free_count <= free_count - 1'b1;
          cursor     <= free_top;
        end
        CMD_SRCH_INIT: begin
          walk   <= head;
          steps  <= '0;
          cursor <= '0;
        end
        CMD_SRCH_LOAD: begin
          if (walk != '0) begin
            wx <= xm[AW'(walk - 1'b1)];
            wy <= ym[AW'(walk - 1'b1)];
          end
        end
        CMD_SRCH_STEP: begin
          if (walk != '0 && wx == kx && wy == ky) begin
            cursor <= walk;
          end else begin
            walk  <= next_mem[walk];
            steps <= steps + 1'b1;
          end
        end
        CMD_CLEAR: begin
          head    <= '0;
          tail    <= '0;
          cursor  <= '0;
          free_count <= FW'(CAPACITY);
          clr_run <= 1'b1;
          clr_idx <= '0;
        end
        CMD_CLR_STEP: begin
          // refill the free stack, one slot a cycle
          free_mem[clr_idx] <= NW'(CAPACITY) - NW'(clr_idx);
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == AW'(CAPACITY - 1)) clr_run <= 1'b0;
        end
        CMD_FETCH: begin
          if (cursor != '0) begin
            rx <= xm[AW'(cursor - 1'b1)];
            ry <= ym[AW'(cursor - 1'b1)];
          end
        end
        default: ;
      endcase
    end
  end

  assign stat.list_empty = (head == '0);
  assign stat.off        = (cursor == '0);
  assign stat.full       = (free_count == '0);
  assign stat.walk_hit   = (walk != '0) && (wx == kx) && (wy == ky);
  assign stat.walk_end   = (walk == '0) || (steps >= FW'(CAPACITY));
  assign stat.clr_done   = !clr_run;

  assign on_entry = (cursor != '0);
  assign out_x = on_entry ? 16'(signed'(rx)) : '0;
  assign out_y = on_entry ? 16'(signed'(ry)) : '0;

endmodule

// File: design/cls_ctrl.sv
module cls_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [3:0]          action,
  output logic                out_valid,
  input  logic                out_ready,
  output cls_pkg::cls_cmd_t   cmd,
  input  cls_pkg::cls_stat_t  stat,
  output logic                found,
  output logic [1:0]          status
);
  import cls_pkg::*;

  localparam logic [2:0] S_CLR   = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_WALK  = 3'd3;
  localparam logic [2:0] S_FETCH = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;
  localparam logic [2:0] S_LOAD  = 3'd6;

  logic [2:0] state;
  logic [3:0] act;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    cmd.op        = CMD_NONE;
    case (state)
      S_CLR:  if (!stat.clr_done) cmd.op = CMD_CLR_STEP;
      S_IDLE: if (in_valid) cmd.op = CMD_LATCH;
      S_EXEC: begin
        case (act)
          ACT_HEAD:   if (!stat.list_empty) cmd.op = CMD_MOVE_HEAD;
          ACT_TAIL:   if (!stat.list_empty) cmd.op = CMD_MOVE_TAIL;
          ACT_PREV:   if (!stat.off) cmd.op = CMD_MOVE_PREV;
          ACT_NEXT:   if (!stat.off) cmd.op = CMD_MOVE_NEXT;
          ACT_REMOVE: if (!stat.off) cmd.op = CMD_REMOVE;
          ACT_INSERT: if (!(!stat.list_empty && stat.off) && !stat.full) cmd.op = CMD_INSERT;
          ACT_SEARCH: cmd.op = CMD_SRCH_INIT;
          ACT_CLEAR:  cmd.op = CMD_CLEAR;
          default:    cmd.op = CMD_NONE;
        endcase
      end
      S_LOAD:  cmd.op = CMD_SRCH_LOAD;
      S_WALK:  if (!stat.walk_end) cmd.op = CMD_SRCH_STEP;
      S_FETCH: cmd.op = CMD_FETCH;
      default: cmd.op = CMD_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_CLR;
      act    <= '0;
      found  <= 1'b0;
      status <= ST_DONE;
    end else begin
      case (state)
        // a clear still owes its result beat; the pass after reset does not
        S_CLR: if (stat.clr_done) state <= (act == ACT_CLEAR) ? S_FETCH : S_IDLE;
        S_IDLE: if (in_valid) begin
          act    <= action;
          found  <= 1'b0;
          status <= ST_DONE;
          state  <= S_EXEC;
        end
        S_EXEC: begin
          state <= S_FETCH;
          case (act)
            ACT_HEAD, ACT_TAIL: if (stat.list_empty) status <= ST_REFUSED;
            ACT_PREV, ACT_NEXT, ACT_READ, ACT_REMOVE: if (stat.off) status <= ST_REFUSED;
            ACT_INSERT:
              if (!stat.list_empty && stat.off) status <= ST_REFUSED;
              else if (stat.full) status <= ST_FULL;
            ACT_SEARCH: state <= S_LOAD;
            ACT_CLEAR:  state <= S_CLR;
            default:    status <= ST_REFUSED;
          endcase
        end
        S_LOAD: state <= S_WALK;
        S_WALK: begin
          if (stat.walk_end) state <= S_FETCH;
          else if (stat.walk_hit) begin
            found <= 1'b1;
            state <= S_FETCH;
          end else state <= S_LOAD;
        end
        S_FETCH: state <= S_OUT;
        S_OUT: if (out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: design/cursor_linked_list_store.sv
// Cursor linked list store: a bounded doubly linked list of (x, y) entries
// with a cursor. One item in, one result beat out; the next item is taken
// only after the result beat leaves. The link store is read one registered
// access a cycle, which sets the timing. Cursor moves, read, remove and
// insert latch the item, act, fetch the entry under the cursor and then hold
// the result beat until out_ready. Search loads and compares each node in
// turn (one more load at the end of the list). Clear refills the free stack
// one slot a cycle; after reset no item is taken until that refill is done.
module cursor_linked_list_store #(
  parameter int CAPACITY    = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0]         action,
  input  logic signed [15:0] coord_x,
  input  logic signed [15:0] coord_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_x,
  output logic signed [15:0] out_y,
  output logic               on_entry,
  output logic               found,
  output logic               is_empty,
  output logic [1:0]         status
);
  import cls_pkg::*;

  cls_cmd_t  cmd;
  cls_stat_t stat;

  // sequence each action
  cls_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .action, .out_valid, .out_ready,
    .cmd, .stat, .found, .status
  );

  // hold links, entries and free stack
  cls_datapath #(.CAPACITY(CAPACITY)) u_dp (
    .clk, .rst, .cmd, .stat, .coord_x, .coord_y, .out_x, .out_y, .on_entry
  );

  assign is_empty = stat.list_empty;

endmodule
